>>> rtl/wpitc_pkg.sv
// Shared types, codes and reset values of the windowed PI temperature controller.
package wpitc_pkg;

  // Fixed field widths
  localparam int unsigned TEMP_W = 13;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned ERR_W  = 14;
  localparam int unsigned DUTY_W = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Shared multiplier operand and product widths
  localparam int unsigned MUL_W  = 17;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Default integral accumulator width
  localparam int unsigned INTEGRAL_BITS_DEF = 40;

  // Duty saturation
  localparam logic [DUTY_W-1:0] DUTY_FULL = 17'h10000;
  // Smallest total (2^-20 units) whose duty would exceed full scale
  localparam int unsigned DUTY_SAT_TOTAL = 1048592;

  // Output region codes
  typedef enum logic [1:0] {
    REGION_FULL_ON  = 2'd0,
    REGION_OFF      = 2'd1,
    REGION_REGULATE = 2'd2
  } region_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_TEMP  = 3'd0,
    CFG_PROP_GAIN    = 3'd1,
    CFG_INTEG_GAIN   = 3'd2,
    CFG_DERIV_GAIN   = 3'd3,
    CFG_TICK_PERIOD  = 3'd4,
    CFG_WINDOW_ABOVE = 3'd5,
    CFG_WINDOW_BELOW = 3'd6
  } cfg_idx_e;

  // Reset values
  localparam logic [TEMP_W-1:0] TARGET_TEMP_RST  = 13'd5600;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST    = 16'd5603;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST   = 16'd5046;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST   = 16'd0;
  localparam logic [GAIN_W-1:0] TICK_PERIOD_RST  = 16'd6554;
  localparam logic [TEMP_W-1:0] WINDOW_ABOVE_RST = 13'd240;
  localparam logic [TEMP_W-1:0] WINDOW_BELOW_RST = 13'd800;

  // Register file contents handed to the datapath
  typedef struct packed {
    logic [TEMP_W-1:0] target_temp;
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [GAIN_W-1:0] tick_period;
    logic [TEMP_W-1:0] window_above;
    logic [TEMP_W-1:0] window_below;
  } cfg_t;

endpackage

>>> rtl/wpitc_cfg.sv
// Configuration register file of the windowed PI temperature controller.
module wpitc_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wpitc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wpitc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output wpitc_pkg::cfg_t                    cfg_o
);

  wpitc_pkg::cfg_t cfg_q;

  // Write decode; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_temp  <= wpitc_pkg::TARGET_TEMP_RST;
      cfg_q.prop_gain    <= wpitc_pkg::PROP_GAIN_RST;
      cfg_q.integ_gain   <= wpitc_pkg::INTEG_GAIN_RST;
      cfg_q.deriv_gain   <= wpitc_pkg::DERIV_GAIN_RST;
      cfg_q.tick_period  <= wpitc_pkg::TICK_PERIOD_RST;
      cfg_q.window_above <= wpitc_pkg::WINDOW_ABOVE_RST;
      cfg_q.window_below <= wpitc_pkg::WINDOW_BELOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wpitc_pkg::CFG_TARGET_TEMP:  cfg_q.target_temp  <= cfg_wdata_i[wpitc_pkg::TEMP_W-1:0];
        wpitc_pkg::CFG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_wdata_i;
        wpitc_pkg::CFG_INTEG_GAIN:   cfg_q.integ_gain   <= cfg_wdata_i;
        wpitc_pkg::CFG_DERIV_GAIN:   cfg_q.deriv_gain   <= cfg_wdata_i;
        wpitc_pkg::CFG_TICK_PERIOD:  cfg_q.tick_period  <= cfg_wdata_i;
        wpitc_pkg::CFG_WINDOW_ABOVE: cfg_q.window_above <= cfg_wdata_i[wpitc_pkg::TEMP_W-1:0];
        wpitc_pkg::CFG_WINDOW_BELOW: cfg_q.window_below <= cfg_wdata_i[wpitc_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/wpitc_mul.sv
// Shared signed 17x17 multiplier with a registered product.
module wpitc_mul (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [wpitc_pkg::MUL_W-1:0]      a_i,
  input  logic signed [wpitc_pkg::MUL_W-1:0]      b_i,
  output logic signed [wpitc_pkg::PROD_W-1:0]     p_o
);

  logic signed [wpitc_pkg::PROD_W-1:0] p_q;

  // Product register, loaded only when an operand pair is issued
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= wpitc_pkg::PROD_W'(a_i) * wpitc_pkg::PROD_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/windowed_pi_temperature_controller_unit.sv
// Top level of the windowed PI temperature controller: sequencer and datapath.
// One measured temperature in, one heater duty and region out per request. A request
// outside the window goes from ST_ERR straight to ST_OUT. A
// regulating request runs every product through one shared 17x17 multiplier, in a
// multiply state and an accumulate state each: the integral step, then
// ceil(min(INTEGRAL_BITS,49)/16) slices of the integral-times-gain product, then
// the proportional and derivative terms. in_stall_o is high while a request is in
// work; the result register lets a new request in while the last result still
// waits on out_stall_i.
module windowed_pi_temperature_controller_unit #(
  parameter int unsigned INTEGRAL_BITS = wpitc_pkg::INTEGRAL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [wpitc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wpitc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [wpitc_pkg::TEMP_W-1:0]        measured_temp_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [wpitc_pkg::DUTY_W-1:0]        duty_o,
  output logic [1:0]                          region_o
);

  localparam int unsigned MW   = wpitc_pkg::MUL_W;
  localparam int unsigned PRW  = wpitc_pkg::PROD_W;
  localparam int unsigned EW   = wpitc_pkg::ERR_W;
  // integral update width
  localparam int unsigned SW   = ((INTEGRAL_BITS > PRW) ? INTEGRAL_BITS : PRW) + 1;
  // clamped integral widths
  localparam int unsigned XW   = (INTEGRAL_BITS > 49) ? INTEGRAL_BITS : 49;
  localparam int unsigned ICW  = (INTEGRAL_BITS > 48) ? 49 : INTEGRAL_BITS;
  localparam int unsigned NCH  = (ICW + 15) / 16;
  localparam int unsigned KW   = $clog2(NCH);
  localparam int unsigned CHW  = 16 * NCH + 1;
  localparam int unsigned PW   = ICW + MW;
  localparam int unsigned TW   = ((ICW > 32) ? ICW : 32) + 2;
  localparam logic [KW-1:0] K_TOP = KW'(NCH - 1);

  localparam logic signed [SW-1:0] INT_HI =
    {{(SW - INTEGRAL_BITS + 1){1'b0}}, {(INTEGRAL_BITS - 1){1'b1}}};
  localparam logic signed [SW-1:0] INT_LO = ~INT_HI;
  localparam logic signed [XW-1:0] IC_LIM = {{(XW - 48){1'b0}}, 1'b1, {47{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_DLT_MUL,
    ST_DLT_ADD,
    ST_I_MUL,
    ST_I_ACC,
    ST_P_MUL,
    ST_P_ACC,
    ST_D_MUL,
    ST_D_ACC,
    ST_CLAMP,
    ST_OUT
  } state_e;

  wpitc_pkg::cfg_t cfg;

  state_e                           state_q;
  logic [wpitc_pkg::TEMP_W-1:0]     temp_q;
  logic signed [EW-1:0]             err_q;
  logic signed [EW-1:0]             prev_err_q;
  logic signed [INTEGRAL_BITS-1:0]  integ_q;
  logic signed [PW-1:0]             acc_q;
  logic signed [TW-1:0]             total_q;
  logic [KW-1:0]                    k_q;
  logic [wpitc_pkg::DUTY_W-1:0]     res_duty_q;
  wpitc_pkg::region_e               res_region_q;
  logic                             out_valid_q;
  logic [wpitc_pkg::DUTY_W-1:0]     out_duty_q;
  wpitc_pkg::region_e               out_region_q;

  logic signed [EW-1:0]             err_c;
  logic                             err_hi;
  logic                             err_lo;
  logic signed [EW:0]               diff_c;
  logic signed [SW-1:0]             sum_c;
  logic signed [INTEGRAL_BITS-1:0]  integ_sat;
  logic signed [XW-1:0]             integ_x;
  logic signed [XW-1:0]             ic_c;
  logic signed [ICW-1:0]            ic_n;
  logic signed [CHW-1:0]            ic_sh;
  logic signed [MW-1:0]             chunk_c;
  logic                             mul_en;
  logic signed [MW-1:0]             mul_a;
  logic signed [MW-1:0]             mul_b;
  logic signed [PRW-1:0]            prod;
  logic                             out_load;

  wpitc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  wpitc_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Error and window decision
  always_comb begin
    err_c  = $signed({1'b0, cfg.target_temp}) - $signed({1'b0, temp_q});
    err_hi = err_c > $signed({1'b0, cfg.window_below});
    err_lo = err_c < -$signed({1'b0, cfg.window_above});
    diff_c = $signed({err_q[EW-1], err_q}) - $signed({prev_err_q[EW-1], prev_err_q});
  end

  // Saturating integral update with the registered delta product
  always_comb begin
    sum_c = SW'(integ_q) + SW'(prod);
    if (sum_c > INT_HI) begin
      integ_sat = INTEGRAL_BITS'(INT_HI);
    end else if (sum_c < INT_LO) begin
      integ_sat = INTEGRAL_BITS'(INT_LO);
    end else begin
      integ_sat = INTEGRAL_BITS'(sum_c);
    end
  end

  // Clamped integral, cut into 16-bit slices; the top slice carries the sign
  always_comb begin
    integ_x = XW'(integ_q);
    if (integ_x > IC_LIM) begin
      ic_c = IC_LIM;
    end else if (integ_x < -IC_LIM) begin
      ic_c = -IC_LIM;
    end else begin
      ic_c = integ_x;
    end
    ic_n    = ic_c[ICW-1:0];
    ic_sh   = CHW'(ic_n) >>> {k_q, 4'b0000};
    chunk_c = ic_sh[MW-1:0];
    if (k_q != K_TOP) begin
      chunk_c[MW-1] = 1'b0;
    end
  end

  // Multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_DLT_MUL: begin
        mul_en = 1'b1;
        mul_a  = MW'(err_q);
        mul_b  = $signed({1'b0, cfg.tick_period});
      end
      ST_I_MUL: begin
        mul_en = 1'b1;
        mul_a  = chunk_c;
        mul_b  = $signed({1'b0, cfg.integ_gain});
      end
      ST_P_MUL: begin
        mul_en = 1'b1;
        mul_a  = MW'(err_q);
        mul_b  = $signed({1'b0, cfg.prop_gain});
      end
      ST_D_MUL: begin
        mul_en = 1'b1;
        mul_a  = MW'(diff_c);
        mul_b  = $signed({1'b0, cfg.deriv_gain});
      end
      default: ;
    endcase
  end

  // Result register takes the finished request once it is empty or draining
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // Sequencer, state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      integ_q     <= '0;
      prev_err_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q  <= 1'b1;
        out_duty_q   <= res_duty_q;
        out_region_q <= res_region_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            temp_q  <= measured_temp_i;
            state_q <= ST_ERR;
          end
        end
        ST_ERR: begin
          err_q <= err_c;
          if (err_hi) begin
            integ_q      <= '0;
            res_duty_q   <= wpitc_pkg::DUTY_FULL;
            res_region_q <= wpitc_pkg::REGION_FULL_ON;
            state_q      <= ST_OUT;
          end else if (err_lo) begin
            integ_q      <= '0;
            res_duty_q   <= '0;
            res_region_q <= wpitc_pkg::REGION_OFF;
            state_q      <= ST_OUT;
          end else begin
            state_q <= ST_DLT_MUL;
          end
        end
        ST_DLT_MUL: begin
          state_q <= ST_DLT_ADD;
        end
        ST_DLT_ADD: begin
          integ_q <= integ_sat;
          acc_q   <= '0;
          k_q     <= K_TOP;
          state_q <= ST_I_MUL;
        end
        ST_I_MUL: begin
          state_q <= ST_I_ACC;
        end
        ST_I_ACC: begin
          acc_q <= (acc_q <<< 16) + PW'(prod);
          if (k_q == '0) begin
            state_q <= ST_P_MUL;
          end else begin
            k_q     <= k_q - 1'b1;
            state_q <= ST_I_MUL;
          end
        end
        ST_P_MUL: begin
          state_q <= ST_P_ACC;
        end
        ST_P_ACC: begin
          // floor(integral term / 2^16) plus proportional term
          total_q <= TW'(acc_q >>> 16) + TW'(prod);
          state_q <= ST_D_MUL;
        end
        ST_D_MUL: begin
          state_q <= ST_D_ACC;
        end
        ST_D_ACC: begin
          total_q <= total_q - TW'(prod);
          state_q <= ST_CLAMP;
        end
        ST_CLAMP: begin
          if (total_q[TW-1]) begin
            res_duty_q <= '0;
          end else if (total_q >= TW'(wpitc_pkg::DUTY_SAT_TOTAL)) begin
            res_duty_q <= wpitc_pkg::DUTY_FULL;
          end else begin
            res_duty_q <= total_q[wpitc_pkg::DUTY_W+3:4];
          end
          res_region_q <= wpitc_pkg::REGION_REGULATE;
          state_q      <= ST_OUT;
        end
        ST_OUT: begin
          // error of this tick becomes the previous error, in every region
          prev_err_q <= err_q;
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign duty_o      = out_duty_q;
  assign region_o    = out_region_q;

  // Checks
  a_full_on_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_region_q == wpitc_pkg::REGION_FULL_ON) |->
      (out_duty_q == wpitc_pkg::DUTY_FULL))
    else $error("full-on region without full duty");

  a_off_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_region_q == wpitc_pkg::REGION_OFF) |-> (out_duty_q == '0))
    else $error("off region with nonzero duty");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_duty_q <= wpitc_pkg::DUTY_FULL))
    else $error("duty above full scale");

  a_integ_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ERR && (err_hi || err_lo)) |=> (integ_q == '0))
    else $error("integral not cleared outside window");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && out_stall_i) |=> (state_q == ST_OUT))
    else $error("result left while output register busy");

endmodule

>>> sim/windowed_pi_temperature_controller_unit_tb.sv
// Self-checking testbench of the windowed PI temperature controller unit.
module windowed_pi_temperature_controller_unit_tb;

  localparam int INTEG_BITS = wpitc_pkg::INTEGRAL_BITS_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int SAT_TICKS = 12;
  localparam int RAND_PHASES = 8;
  localparam int RAND_ITEMS = 64;

  typedef struct {
    logic [wpitc_pkg::DUTY_W-1:0] duty;
    wpitc_pkg::region_e           region;
  } duty_result_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [wpitc_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [wpitc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [wpitc_pkg::TEMP_W-1:0]     measured_temp = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [wpitc_pkg::DUTY_W-1:0]     duty;
  logic [1:0]                       region;

  windowed_pi_temperature_controller_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .measured_temp_i(measured_temp),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .duty_o         (duty),
    .region_o       (region)
  );

  always #5 clk_i = ~clk_i;

  // Controller model: register copies and loop state
  int     cfg_target = wpitc_pkg::TARGET_TEMP_RST;
  int     cfg_prop   = wpitc_pkg::PROP_GAIN_RST;
  int     cfg_integ  = wpitc_pkg::INTEG_GAIN_RST;
  int     cfg_deriv  = wpitc_pkg::DERIV_GAIN_RST;
  int     cfg_period = wpitc_pkg::TICK_PERIOD_RST;
  int     cfg_above  = wpitc_pkg::WINDOW_ABOVE_RST;
  int     cfg_below  = wpitc_pkg::WINDOW_BELOW_RST;
  longint integ_acc  = 0;
  longint last_err   = 0;

  // Stimulus and scoreboard state
  logic [wpitc_pkg::TEMP_W-1:0] temp_backlog[$];
  duty_result_t      predicted_duties[$];
  int n_pushed = 0;
  int n_taken = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_settings = 0;
  int region_hits[3] = '{0, 0, 0};
  int gap_max = 0;
  int stall_style = 0;
  int hold_ask = 0;

  // One control tick of the model: window test, integral update, PID sum, clamp
  function automatic duty_result_t control_tick(logic [wpitc_pkg::TEMP_W-1:0] temp);
    longint err, delta, hi, lo, ic, total, q;
    duty_result_t r;
    hi = (longint'(1) <<< (INTEG_BITS - 1)) - 1;
    lo = -hi - 1;
    err = longint'(cfg_target) - longint'({1'b0, temp});
    if (err > cfg_below) begin
      r.duty = wpitc_pkg::DUTY_FULL;
      r.region = wpitc_pkg::REGION_FULL_ON;
      integ_acc = 0;
    end else if (err < -cfg_above) begin
      r.duty = '0;
      r.region = wpitc_pkg::REGION_OFF;
      integ_acc = 0;
    end else begin
      delta = err * longint'(cfg_period);
      if (delta > 0 && integ_acc > hi - delta) integ_acc = hi;
      else if (delta < 0 && integ_acc < lo - delta) integ_acc = lo;
      else integ_acc = integ_acc + delta;
      ic = integ_acc;
      if (ic > (longint'(1) <<< 47)) ic = longint'(1) <<< 47;
      if (ic < -(longint'(1) <<< 47)) ic = -(longint'(1) <<< 47);
      // arithmetic shift gives the floor division by 2^16
      total = longint'(cfg_prop) * err + ((ic * longint'(cfg_integ)) >>> 16)
            - longint'(cfg_deriv) * (err - last_err);
      if (total < 0) begin
        r.duty = '0;
      end else begin
        q = total >>> 4;
        if (q > longint'(wpitc_pkg::DUTY_FULL)) q = longint'(wpitc_pkg::DUTY_FULL);
        r.duty = wpitc_pkg::DUTY_W'(q);
      end
      r.region = wpitc_pkg::REGION_REGULATE;
    end
    last_err = err;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // Driver: bursts of requests with random gaps between them
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      measured_temp <= '0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (temp_backlog.size() > 0) begin
        in_valid <= 1'b1;
        measured_temp <= temp_backlog.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(15, 0);
          gap_left = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  int hold_seen = 0;
  int hold_left = 0;
  int run_left = 0;
  bit run_high = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(3, 0) == 0);
          default: begin
            if (run_left > 0) begin
              run_left--;
            end else begin
              run_left = $urandom_range(12, 1);
              run_high = !run_high;
            end
            out_stall <= run_high;
          end
        endcase
      end
    end
  end

  // Monitor: check results in order, then predict for newly accepted requests
  always @(posedge clk_i) begin : monitor
    duty_result_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (region < 3) region_hits[region]++;
        if (predicted_duties.size() == 0) begin
          report_mismatch($sformatf("unexpected result duty=%0d region=%0d", duty, region));
        end else begin
          want = predicted_duties.pop_front();
          if (duty !== want.duty)
            report_mismatch($sformatf("duty got %0d want %0d", duty, want.duty));
          if (region !== want.region)
            report_mismatch($sformatf("region got %0d want %0d", region, want.region));
        end
      end
      if (in_valid && !in_stall) begin
        predicted_duties.push_back(control_tick(measured_temp));
        n_taken++;
      end
    end
  end

  task automatic send_temp(int t);
    if (t < 0) t = 0;
    if (t > 8191) t = 8191;
    temp_backlog.push_back(wpitc_pkg::TEMP_W'(t));
    n_pushed++;
  endtask

  // Request for a given error against the current setpoint
  task automatic send_err(int e);
    send_temp(cfg_target - e);
  endtask

  // Wait until every request is taken and answered, then let the pipe drain
  task automatic settle();
    while (n_taken != n_pushed || predicted_duties.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic write_reg(wpitc_pkg::cfg_idx_e idx,
                           logic [wpitc_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      wpitc_pkg::CFG_TARGET_TEMP:  cfg_target = data[wpitc_pkg::TEMP_W-1:0];
      wpitc_pkg::CFG_PROP_GAIN:    cfg_prop = data;
      wpitc_pkg::CFG_INTEG_GAIN:   cfg_integ = data;
      wpitc_pkg::CFG_DERIV_GAIN:   cfg_deriv = data;
      wpitc_pkg::CFG_TICK_PERIOD:  cfg_period = data;
      wpitc_pkg::CFG_WINDOW_ABOVE: cfg_above = data[wpitc_pkg::TEMP_W-1:0];
      wpitc_pkg::CFG_WINDOW_BELOW: cfg_below = data[wpitc_pkg::TEMP_W-1:0];
      default: ;
    endcase
  endtask

  // Random register value: often an extreme, otherwise uniform
  function automatic int pick_value(int top);
    int r;
    r = $urandom_range(9, 0);
    if (r < 2) return 0;
    if (r < 4) return top;
    return $urandom_range(top, 0);
  endfunction

  function automatic logic [wpitc_pkg::CFG_DATA_W-1:0] pick_temp_reg();
    return {3'($urandom_range(7, 0)), wpitc_pkg::TEMP_W'(pick_value(8191))};
  endfunction

  initial begin : stimulus
    int r, e;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: extremes, window edges and just past them
    n_settings++;
    stall_style = 1;
    gap_max = 4;
    send_temp(0);
    send_temp(8191);
    send_err(0);
    send_err(800);
    send_err(801);
    send_err(-240);
    send_err(-241);
    send_err(100);
    send_err(-50);
    settle();

    // All registers at their extremes, upper data bits set, zero tick period
    n_settings++;
    write_reg(wpitc_pkg::CFG_TARGET_TEMP, 16'hFFFF);
    write_reg(wpitc_pkg::CFG_PROP_GAIN, 16'hFFFF);
    write_reg(wpitc_pkg::CFG_INTEG_GAIN, 16'hFFFF);
    write_reg(wpitc_pkg::CFG_DERIV_GAIN, 16'hFFFF);
    write_reg(wpitc_pkg::CFG_TICK_PERIOD, 16'h0000);
    write_reg(wpitc_pkg::CFG_WINDOW_ABOVE, 16'hE000);
    write_reg(wpitc_pkg::CFG_WINDOW_BELOW, 16'hE000);
    stall_style = 2;
    send_temp(8191);
    send_temp(0);
    send_temp(8191);
    send_temp(8190);
    send_temp(8191);
    settle();
    n_settings++;
    write_reg(wpitc_pkg::CFG_WINDOW_ABOVE, 16'hFFFF);
    write_reg(wpitc_pkg::CFG_WINDOW_BELOW, 16'h0001);
    write_reg(wpitc_pkg::CFG_TARGET_TEMP, 16'h0000);
    send_temp(8191);
    send_temp(0);
    send_err(1);
    send_err(2);
    settle();

    // Build up a large positive integral, then expose it
    n_settings++;
    stall_style = 0;
    gap_max = 0;
    write_reg(wpitc_pkg::CFG_TARGET_TEMP, 16'd8191);
    write_reg(wpitc_pkg::CFG_WINDOW_BELOW, 16'd8191);
    write_reg(wpitc_pkg::CFG_WINDOW_ABOVE, 16'd0);
    write_reg(wpitc_pkg::CFG_TICK_PERIOD, 16'hFFFF);
    write_reg(wpitc_pkg::CFG_PROP_GAIN, 16'd0);
    write_reg(wpitc_pkg::CFG_INTEG_GAIN, 16'd0);
    write_reg(wpitc_pkg::CFG_DERIV_GAIN, 16'd0);
    repeat (SAT_TICKS) send_temp(0);
    settle();
    write_reg(wpitc_pkg::CFG_TICK_PERIOD, 16'd0);
    write_reg(wpitc_pkg::CFG_INTEG_GAIN, 16'd1);
    write_reg(wpitc_pkg::CFG_PROP_GAIN, 16'hFFFF);
    write_reg(wpitc_pkg::CFG_WINDOW_ABOVE, 16'd200);
    write_reg(wpitc_pkg::CFG_TARGET_TEMP, 16'd0);
    send_temp(127);
    send_temp(8191);
    settle();

    // Same for a large negative integral
    n_settings++;
    write_reg(wpitc_pkg::CFG_WINDOW_ABOVE, 16'd8191);
    write_reg(wpitc_pkg::CFG_TICK_PERIOD, 16'hFFFF);
    write_reg(wpitc_pkg::CFG_PROP_GAIN, 16'd0);
    write_reg(wpitc_pkg::CFG_INTEG_GAIN, 16'd0);
    repeat (SAT_TICKS) send_temp(8191);
    settle();
    write_reg(wpitc_pkg::CFG_TICK_PERIOD, 16'd0);
    write_reg(wpitc_pkg::CFG_INTEG_GAIN, 16'd1);
    write_reg(wpitc_pkg::CFG_PROP_GAIN, 16'hFFFF);
    write_reg(wpitc_pkg::CFG_WINDOW_BELOW, 16'd200);
    write_reg(wpitc_pkg::CFG_TARGET_TEMP, 16'd129);
    send_temp(0);
    settle();

    // Random settings, mostly regulating requests near the setpoint
    for (int p = 0; p < RAND_PHASES; p++) begin
      n_settings++;
      write_reg(wpitc_pkg::CFG_TARGET_TEMP, pick_temp_reg());
      write_reg(wpitc_pkg::CFG_PROP_GAIN, wpitc_pkg::CFG_DATA_W'(pick_value(65535)));
      write_reg(wpitc_pkg::CFG_INTEG_GAIN, wpitc_pkg::CFG_DATA_W'(pick_value(65535)));
      write_reg(wpitc_pkg::CFG_DERIV_GAIN, ($urandom_range(2, 0) == 0) ? '0 :
                wpitc_pkg::CFG_DATA_W'(pick_value(65535)));
      write_reg(wpitc_pkg::CFG_TICK_PERIOD, wpitc_pkg::CFG_DATA_W'(pick_value(65535)));
      write_reg(wpitc_pkg::CFG_WINDOW_ABOVE, pick_temp_reg());
      write_reg(wpitc_pkg::CFG_WINDOW_BELOW, pick_temp_reg());
      stall_style = p % 3;
      r = $urandom_range(2, 0);
      gap_max = (r == 0) ? 0 : ((r == 1) ? 3 : 10);
      if (p == 3) hold_ask++;
      for (int i = 0; i < RAND_ITEMS; i++) begin
        r = $urandom_range(99, 0);
        if (r < 65) begin
          e = int'($urandom_range(cfg_above + cfg_below + 4, 0)) - cfg_above - 2;
          send_err(e);
        end else if (r < 75) begin
          case ($urandom_range(3, 0))
            0: send_err(cfg_below);
            1: send_err(cfg_below + 1);
            2: send_err(-cfg_above);
            default: send_err(-cfg_above - 1);
          endcase
        end else begin
          send_temp($urandom_range(8191, 0));
        end
      end
      settle();
    end

    repeat (40) @(posedge clk_i);
    $display("Ran %0d requests under %0d register settings, %0d results checked",
             n_taken, n_settings, n_results);
    $display("Regions seen: %0d full on, %0d off, %0d regulating",
             region_hits[0], region_hits[1], region_hits[2]);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding", predicted_duties.size());
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/wpitc_pkg.sv
rtl/wpitc_cfg.sv
rtl/wpitc_mul.sv
rtl/windowed_pi_temperature_controller_unit.sv
sim/windowed_pi_temperature_controller_unit_tb.sv
